[hdl/ppfs_pkg.sv]
// Package for the pulse period / frequency statistics block.
// Holds controller states, divider operand codes, command and status structs and constants.
// No dependencies.
package ppfs_pkg;

  // Fixed widths of the interface fields.
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned DEB_W     = 16;
  localparam int unsigned FREQ_W    = 36;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned DIVISOR_W = 32;

  // Configuration port layout: one 32-bit register per word.
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam logic        REG_IDX_DEBOUNCE = 1'b0;
  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd500;

  // 1e6 * 65536: one microsecond period expressed in Hz with 16 fraction bits.
  localparam logic [FREQ_W-1:0] FREQ_SCALE = 36'd65536000000;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK_INIT,
    ST_WALK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

  // Which quotient the shared divider is producing.
  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_FMEAN,
    DIV_FMAX,
    DIV_FMIN
  } div_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     walk_init;
    logic     walk;
    logic     div_start;
    logic     div_store;
    div_sel_t div_sel;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ring_empty;
    logic walk_done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

[hdl/pulse_period_frequency_stats.sv]
// Pulse period / frequency statistics: top level with the APB debounce register.
// Each edge goes through a window walk (one ring read a cycle) and then four quotients of
// Q = max(36, 32+clog2(WINDOW+1)) bits from the shared one-bit-a-cycle divider; while the
// ring is empty both are skipped and zero frequencies are reported. One edge
// is in work at a time; the next is taken once the result is in the output register.
// Synchronous reset clears the control state and sets debounce_us to 500; ring not cleared.
module pulse_period_frequency_stats #(
  parameter int unsigned WINDOW = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ppfs_pkg::TIME_W-1:0]     edge_time_us,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            accepted,
  output logic [ppfs_pkg::COUNT_W-1:0]    stored_count,
  output logic [ppfs_pkg::FREQ_W-1:0]     mean_freq,
  output logic [ppfs_pkg::FREQ_W-1:0]     max_freq,
  output logic [ppfs_pkg::FREQ_W-1:0]     min_freq,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ppfs_pkg::ADDR_W-1:0]     paddr,
  input  logic [ppfs_pkg::PDATA_W-1:0]    pwdata,
  output logic [ppfs_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  logic [ppfs_pkg::DEB_W-1:0] debounce_us;
  ppfs_pkg::cmd_t             cmd;
  ppfs_pkg::status_t          status;

  // Configuration register, word index taken from paddr[2].
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_us <= ppfs_pkg::DEBOUNCE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == ppfs_pkg::REG_IDX_DEBOUNCE)) begin
      debounce_us <= pwdata[ppfs_pkg::DEB_W-1:0];
    end
  end

  // Register readback.
  always_comb begin
    if (paddr[2] == ppfs_pkg::REG_IDX_DEBOUNCE) begin
      prdata = ppfs_pkg::PDATA_W'(debounce_us);
    end else begin
      prdata = '0;
    end
  end

  ppfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ppfs_datapath #(
    .WINDOW(WINDOW)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .edge_time_us (edge_time_us),
    .debounce_us  (debounce_us),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accepted     (accepted),
    .stored_count (stored_count),
    .mean_freq    (mean_freq),
    .max_freq     (max_freq),
    .min_freq     (min_freq)
  );

endmodule

[hdl/ppfs_divider.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Uses ppfs_pkg for the divisor width.
module ppfs_divider #(
  parameter int unsigned QW = 39
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [QW-1:0]                    dividend,
  input  logic [ppfs_pkg::DIVISOR_W-1:0]   divisor,
  output logic [QW-1:0]                    quotient,
  output logic                             done
);

  localparam int unsigned DW = ppfs_pkg::DIVISOR_W;
  localparam int unsigned CNT_W = $clog2(QW + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    dvsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW:0]      shifted;
  logic             fits;

  // Trial subtraction of the shifted partial remainder.
  assign shifted = {rem, quotient[QW-1]};
  assign fits    = (shifted >= {1'b0, dvsr});
  assign done    = busy && (cnt == '0);

  // Control: busy flag and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(QW);
    end else if (busy && (cnt != '0)) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Datapath: shift the quotient in from the dividend bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvsr     <= divisor;
      quotient <= dividend;
    end else if (busy && (cnt != '0)) begin
      if (fits) begin
        rem <= DW'(shifted - {1'b0, dvsr});
      end else begin
        rem <= shifted[DW-1:0];
      end
      quotient <= {quotient[QW-2:0], fits};
    end
  end

endmodule

[hdl/ppfs_datapath.sv]
// Datapath: period capture, period ring memory, window walk, shared divider, result register.
// Uses ppfs_pkg and instantiates ppfs_divider.
module ppfs_datapath #(
  parameter int unsigned WINDOW = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ppfs_pkg::cmd_t                  cmd,
  output ppfs_pkg::status_t               status,
  input  logic [ppfs_pkg::TIME_W-1:0]     edge_time_us,
  input  logic [ppfs_pkg::DEB_W-1:0]      debounce_us,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            accepted,
  output logic [ppfs_pkg::COUNT_W-1:0]    stored_count,
  output logic [ppfs_pkg::FREQ_W-1:0]     mean_freq,
  output logic [ppfs_pkg::FREQ_W-1:0]     max_freq,
  output logic [ppfs_pkg::FREQ_W-1:0]     min_freq
);

  localparam int unsigned TW = ppfs_pkg::TIME_W;
  localparam int unsigned FW = ppfs_pkg::FREQ_W;
  localparam int unsigned AW = $clog2(WINDOW);
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned SW = TW + CW;
  localparam int unsigned QW = (SW > FW) ? SW : FW;

  logic [TW-1:0] period_ring [WINDOW];
  logic [TW-1:0] rd_data;
  logic          rd_pend;
  logic [CW-1:0] rd_idx;

  logic [TW-1:0] last_edge_time;
  logic [AW-1:0] write_slot;
  logic [CW-1:0] fill_count;
  logic          acc_flag;

  logic [TW-1:0] period;
  logic          pass;

  logic [SW-1:0] sum;
  logic [TW-1:0] tmax;
  logic [TW-1:0] tmin;
  logic [TW-1:0] mean_period;
  logic [FW-1:0] mean_f;
  logic [FW-1:0] max_f;
  logic [FW-1:0] min_f;

  logic [QW-1:0]                  div_dividend;
  logic [ppfs_pkg::DIVISOR_W-1:0] div_divisor;
  logic [QW-1:0]                  div_quotient;
  logic                           div_done;

  // Period since the previous edge, modulo 2^32, and the debounce test.
  assign period = edge_time_us - last_edge_time;
  assign pass   = (period > TW'(debounce_us));

  // Edge bookkeeping: last timestamp, ring slot and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
      write_slot     <= '0;
      fill_count     <= '0;
      acc_flag       <= 1'b0;
    end else if (cmd.capture) begin
      last_edge_time <= edge_time_us;
      acc_flag       <= pass;
      if (pass) begin
        if (write_slot == AW'(WINDOW - 1)) begin
          write_slot <= '0;
        end else begin
          write_slot <= write_slot + 1'b1;
        end
        if (fill_count != CW'(WINDOW)) begin
          fill_count <= fill_count + 1'b1;
        end
      end
    end
  end

  // Period ring: written on an accepted edge, read once per cycle during the walk.
  always_ff @(posedge clk) begin
    if (cmd.capture && pass) begin
      period_ring[write_slot] <= period;
    end
    rd_data <= period_ring[rd_idx[AW-1:0]];
  end

  // Walk control: issue one read address per cycle over the filled slots.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      rd_pend <= 1'b0;
    end else if (cmd.walk_init) begin
      rd_idx  <= '0;
      rd_pend <= 1'b0;
    end else if (cmd.walk) begin
      if (rd_idx != fill_count) begin
        rd_idx  <= rd_idx + 1'b1;
        rd_pend <= 1'b1;
      end else begin
        rd_pend <= 1'b0;
      end
    end
  end

  // Walk accumulation: sum, maximum and minimum of the stored periods.
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      sum  <= '0;
      tmax <= '0;
      tmin <= '1;
    end else if (cmd.walk && rd_pend) begin
      sum <= sum + SW'(rd_data);
      if (rd_data > tmax) begin
        tmax <= rd_data;
      end
      if (rd_data < tmin) begin
        tmin <= rd_data;
      end
    end
  end

  // Divider operands for each of the four quotients.
  always_comb begin
    case (cmd.div_sel)
      ppfs_pkg::DIV_MEAN: begin
        div_dividend = QW'(sum);
        div_divisor  = ppfs_pkg::DIVISOR_W'(fill_count);
      end
      ppfs_pkg::DIV_FMEAN: begin
        div_dividend = QW'(ppfs_pkg::FREQ_SCALE);
        div_divisor  = mean_period;
      end
      ppfs_pkg::DIV_FMAX: begin
        div_dividend = QW'(ppfs_pkg::FREQ_SCALE);
        div_divisor  = tmin;
      end
      default: begin
        div_dividend = QW'(ppfs_pkg::FREQ_SCALE);
        div_divisor  = tmax;
      end
    endcase
  end

  ppfs_divider #(
    .QW(QW)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  // Quotient capture.
  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      case (cmd.div_sel)
        ppfs_pkg::DIV_MEAN:  mean_period <= div_quotient[TW-1:0];
        ppfs_pkg::DIV_FMEAN: mean_f      <= div_quotient[FW-1:0];
        ppfs_pkg::DIV_FMAX:  max_f       <= div_quotient[FW-1:0];
        default:             min_f       <= div_quotient[FW-1:0];
      endcase
    end
  end

  // Output word register; an empty ring reports zero frequencies.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      accepted     <= acc_flag;
      stored_count <= ppfs_pkg::COUNT_W'(fill_count);
      if (fill_count == '0) begin
        mean_freq <= '0;
        max_freq  <= '0;
        min_freq  <= '0;
      end else begin
        mean_freq <= mean_f;
        max_freq  <= max_f;
        min_freq  <= min_f;
      end
    end
  end

  // Status back to the controller.
  always_comb begin
    status.ring_empty = (fill_count == '0);
    status.walk_done  = (rd_idx == fill_count) && !rd_pend;
    status.div_done   = div_done;
    status.out_free   = !out_valid || out_ready;
  end

endmodule

[hdl/ppfs_ctrl.sv]
// Controller state machine: sequences capture, window walk, four divisions and output load.
// Uses ppfs_pkg.
module ppfs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ppfs_pkg::status_t status,
  output ppfs_pkg::cmd_t    cmd
);

  ppfs_pkg::state_t   state;
  ppfs_pkg::state_t   state_next;
  ppfs_pkg::div_sel_t div_sel;
  ppfs_pkg::div_sel_t div_sel_next;

  // State and divider selection registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ppfs_pkg::ST_IDLE;
      div_sel <= ppfs_pkg::DIV_MEAN;
    end else begin
      state   <= state_next;
      div_sel <= div_sel_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next    = state;
    div_sel_next  = div_sel;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.div_sel   = div_sel;
    unique case (state)
      ppfs_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = ppfs_pkg::ST_WALK_INIT;
        end
      end
      ppfs_pkg::ST_WALK_INIT: begin
        cmd.walk_init = 1'b1;
        div_sel_next  = ppfs_pkg::DIV_MEAN;
        if (status.ring_empty) begin
          state_next = ppfs_pkg::ST_FINISH;
        end else begin
          state_next = ppfs_pkg::ST_WALK;
        end
      end
      ppfs_pkg::ST_WALK: begin
        cmd.walk = 1'b1;
        if (status.walk_done) begin
          state_next = ppfs_pkg::ST_DIV_GO;
        end
      end
      ppfs_pkg::ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ppfs_pkg::ST_DIV_WAIT;
      end
      ppfs_pkg::ST_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          unique case (div_sel)
            ppfs_pkg::DIV_MEAN: begin
              div_sel_next = ppfs_pkg::DIV_FMEAN;
              state_next   = ppfs_pkg::ST_DIV_GO;
            end
            ppfs_pkg::DIV_FMEAN: begin
              div_sel_next = ppfs_pkg::DIV_FMAX;
              state_next   = ppfs_pkg::ST_DIV_GO;
            end
            ppfs_pkg::DIV_FMAX: begin
              div_sel_next = ppfs_pkg::DIV_FMIN;
              state_next   = ppfs_pkg::ST_DIV_GO;
            end
            default: begin
              state_next = ppfs_pkg::ST_FINISH;
            end
          endcase
        end
      end
      ppfs_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ppfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ppfs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
